@@ src/hilbert_curve_point_generator_assert.svh @@
// Assertion macros for the Hilbert curve point generator.
// Included by the top level; expects i_clk and i_rst_n in scope.
`ifndef HILBERT_CURVE_POINT_GENERATOR_ASSERT_SVH
`define HILBERT_CURVE_POINT_GENERATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define HCPG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define HCPG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/hcpg_pkg.sv @@
// Shared types and constants for the Hilbert curve point generator.
// No dependencies; used by hcpg_cell and hilbert_curve_point_generator.
package hcpg_pkg;

    localparam int ORG_W   = 16;   // corner coordinate width
    localparam int AXIS_W  = 17;   // side vector component width
    localparam int COORD_W = 18;   // vertex coordinate width
    localparam int LVL_W   = 5;    // levels register width
    localparam int CFG_W   = 17;   // config data width
    localparam int CFG_A_W = 3;    // config index width

    typedef logic signed [AXIS_W-1:0]  t_axis;
    typedef logic signed [COORD_W-1:0] t_coord;

    // Config register indexes
    typedef enum logic [CFG_A_W-1:0] {
        REG_ORIGIN_X      = 3'd0,
        REG_ORIGIN_Y      = 3'd1,
        REG_FIRST_AXIS_X  = 3'd2,
        REG_FIRST_AXIS_Y  = 3'd3,
        REG_SECOND_AXIS_X = 3'd4,
        REG_SECOND_AXIS_Y = 3'd5,
        REG_LEVELS        = 3'd6
    } t_cfg_reg;

    // Child quadrant codes (one base-4 digit of the point index)
    localparam logic [1:0] QUAD_SWAP   = 2'd0;
    localparam logic [1:0] QUAD_FIRST  = 2'd1;
    localparam logic [1:0] QUAD_BOTH   = 2'd2;
    localparam logic [1:0] QUAD_FLIP   = 2'd3;

    // Corner and side vectors of the current sub-square
    typedef struct packed {
        t_coord x;
        t_coord y;
        t_axis  ax;
        t_axis  ay;
        t_axis  bx;
        t_axis  by;
    } t_frame;

    // One result word
    typedef struct packed {
        t_coord x;
        t_coord y;
        logic   valid;
        logic   last;
    } t_result;

    // Signed halving, truncated toward zero
    function automatic t_axis f_half(t_axis a);
        t_axis corr;
        t_axis sum;
        corr    = '0;
        corr[0] = a[AXIS_W-1];
        sum     = a + corr;
        return sum >>> 1;
    endfunction

endpackage

@@ src/hcpg_cell.sv @@
// One level of the Hilbert subdivision: applies one child quadrant transform
// and hands the registered sub-square to the next cell. Uses hcpg_pkg.
module hcpg_cell
    import hcpg_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_token,
    input  t_frame i_frame,
    input  logic   i_enable,
    input  logic [1:0] i_digit,
    output logic   o_token,
    output t_frame o_frame
);

    t_axis  w_hax, w_hay, w_hbx, w_hby;
    t_frame n_frame;
    t_frame r_frame;
    logic   r_token;

    assign w_hax = f_half(i_frame.ax);
    assign w_hay = f_half(i_frame.ay);
    assign w_hbx = f_half(i_frame.bx);
    assign w_hby = f_half(i_frame.by);

    // Quadrant transform; cells above the active depth pass through
    always_comb begin
        n_frame = i_frame;
        if (i_enable) begin
            case (i_digit)
                QUAD_SWAP: begin
                    n_frame.ax = w_hbx;
                    n_frame.ay = w_hby;
                    n_frame.bx = w_hax;
                    n_frame.by = w_hay;
                end
                QUAD_FIRST: begin
                    n_frame.x  = i_frame.x + t_coord'(w_hax);
                    n_frame.y  = i_frame.y + t_coord'(w_hay);
                    n_frame.ax = w_hax;
                    n_frame.ay = w_hay;
                    n_frame.bx = w_hbx;
                    n_frame.by = w_hby;
                end
                QUAD_BOTH: begin
                    n_frame.x  = i_frame.x + t_coord'(w_hax) + t_coord'(w_hbx);
                    n_frame.y  = i_frame.y + t_coord'(w_hay) + t_coord'(w_hby);
                    n_frame.ax = w_hax;
                    n_frame.ay = w_hay;
                    n_frame.bx = w_hbx;
                    n_frame.by = w_hby;
                end
                QUAD_FLIP: begin
                    n_frame.x  = i_frame.x + t_coord'(w_hax) + t_coord'(i_frame.bx);
                    n_frame.y  = i_frame.y + t_coord'(w_hay) + t_coord'(i_frame.by);
                    n_frame.ax = -w_hbx;
                    n_frame.ay = -w_hby;
                    n_frame.bx = -w_hax;
                    n_frame.by = -w_hay;
                end
                default: n_frame = i_frame;
            endcase
        end
    end

    // Token marks the cycle in which this cell holds the live word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_token <= 1'b0;
        end else begin
            r_token <= i_token;
        end
    end

    always_ff @(posedge i_clk) begin
        r_frame <= n_frame;
    end

    assign o_token = r_token;
    assign o_frame = r_frame;

endmodule

@@ src/hilbert_curve_point_generator.sv @@
// Top level of the Hilbert curve point generator: index bookkeeping, the row
// of level cells, vertex output and result buffering. Uses hcpg_pkg, hcpg_cell.
// Usage:
//   Input stream (s_axis): one word per request, tdata bit 0 = restart.
//   restart = 1 starts the curve at its first vertex; restart = 0 asks for the
//   next vertex. Each request yields exactly one result word on m_axis:
//   tdata holds point_x and point_y, tuser is valid_res, tlast is is_last.
//   After the final vertex (tlast = 1) requests give tuser = 0 and zero
//   coordinates until the next restart.
//   Config port: i_cfg_we writes i_cfg_data to register i_cfg_addr; write only
//   while no request is in flight.
// Flow:
//   A vertex passes a row of MAX_LEVELS cells, one level per cycle, from the
//   launch register through each cell's register into the output buffer; a
//   request without a vertex enters the output buffer on acceptance. One vertex
//   at most is in flight; s_axis_tready stays low until it is buffered.
// Reset and stall:
//   Reset restores the default square, 4 levels, and the finished state (no
//   vertex until a restart); s_axis_tready is low in reset. A result waits in
//   a two-entry output buffer; s_axis_tready drops while its second is full.
module hilbert_curve_point_generator
    import hcpg_pkg::*;
#(
    parameter int MAX_LEVELS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // config write port
    input  logic                 i_cfg_we,
    input  logic [CFG_A_W-1:0]   i_cfg_addr,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // request stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [0] restart, [7:1] zero
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [39:0]          m_axis_tdata,   // [17:0] point_x, [35:18] point_y
    output logic                 m_axis_tuser,   // [0] valid_res
    output logic                 m_axis_tlast    // is_last
);

    localparam int IW  = 2 * MAX_LEVELS;
    localparam int LVW = $clog2(MAX_LEVELS + 1);

    // Config registers
    logic [ORG_W-1:0] r_origin_x, r_origin_y;
    t_axis            r_first_axis_x, r_first_axis_y;
    t_axis            r_second_axis_x, r_second_axis_y;
    logic [LVL_W-1:0] r_levels;

    // Traversal state
    logic [IW-1:0]    r_point_index;
    logic             r_finished;
    logic             r_busy;
    logic             r_launch;

    // Output buffer
    t_result          r_out, r_skid;
    logic             r_out_valid, r_skid_valid;

    logic [LVW-1:0]   w_lv;
    logic [IW-1:0]    w_last;
    logic [IW:0]      w_next;
    logic             w_accept, w_restart, w_reject, w_done, w_take, w_push;
    t_result          w_push_res;
    t_frame           w_frame [0:MAX_LEVELS];
    logic [MAX_LEVELS:0] w_token;
    t_axis            w_sum_x_half, w_sum_y_half;
    t_coord           w_sum_x, w_sum_y, w_corr_x, w_corr_y;

    // Effective depth and index of the final vertex
    assign w_lv = (r_levels > LVL_W'(MAX_LEVELS)) ? LVW'(MAX_LEVELS) : r_levels[LVW-1:0];

    for (genvar b = 0; b < IW; b++) begin : g_last
        assign w_last[b] = (w_lv > LVW'(b / 2));
    end

    assign w_accept  = s_axis_tvalid && s_axis_tready;
    assign w_restart = s_axis_tdata[0];
    assign w_next    = w_restart ? '0 : ({1'b0, r_point_index} + (IW+1)'(1));
    assign w_reject  = !w_restart && (r_finished || (w_next > {1'b0, w_last}));

    // Config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x      <= '0;
            r_origin_y      <= '0;
            r_first_axis_x  <= AXIS_W'(256);
            r_first_axis_y  <= '0;
            r_second_axis_x <= '0;
            r_second_axis_y <= AXIS_W'(256);
            r_levels        <= LVL_W'(4);
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_addr))
                REG_ORIGIN_X:      r_origin_x      <= i_cfg_data[ORG_W-1:0];
                REG_ORIGIN_Y:      r_origin_y      <= i_cfg_data[ORG_W-1:0];
                REG_FIRST_AXIS_X:  r_first_axis_x  <= i_cfg_data;
                REG_FIRST_AXIS_Y:  r_first_axis_y  <= i_cfg_data;
                REG_SECOND_AXIS_X: r_second_axis_x <= i_cfg_data;
                REG_SECOND_AXIS_Y: r_second_axis_y <= i_cfg_data;
                REG_LEVELS:        r_levels        <= i_cfg_data[LVL_W-1:0];
                default: ;
            endcase
        end
    end

    // Index bookkeeping and launch into the cell row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_index <= '0;
            r_finished    <= 1'b1;
            r_busy        <= 1'b0;
            r_launch      <= 1'b0;
        end else begin
            r_launch <= 1'b0;
            if (w_accept) begin
                if (w_reject) begin
                    if (!w_restart) begin
                        r_finished <= 1'b1;
                    end
                end else begin
                    r_point_index <= w_next[IW-1:0];
                    r_finished    <= (w_next == {1'b0, w_last});
                    r_busy        <= 1'b1;
                    r_launch      <= 1'b1;
                end
            end else if (w_done) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Starting square
    assign w_token[0] = r_launch;
    assign w_frame[0] = {t_coord'({2'b00, r_origin_x}), t_coord'({2'b00, r_origin_y}),
                         r_first_axis_x, r_first_axis_y,
                         r_second_axis_x, r_second_axis_y};

    // Row of level cells; cell k takes digit MAX_LEVELS-1-k of the index
    for (genvar k = 0; k < MAX_LEVELS; k++) begin : g_cell
        hcpg_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_token  (w_token[k]),
            .i_frame  (w_frame[k]),
            .i_enable (w_lv > LVW'(MAX_LEVELS - 1 - k)),
            .i_digit  (r_point_index[2*(MAX_LEVELS-1-k) +: 2]),
            .o_token  (w_token[k+1]),
            .o_frame  (w_frame[k+1])
        );
    end

    // Vertex = corner + (first + second) / 2, truncated toward zero
    assign w_sum_x  = t_coord'(w_frame[MAX_LEVELS].ax) + t_coord'(w_frame[MAX_LEVELS].bx);
    assign w_sum_y  = t_coord'(w_frame[MAX_LEVELS].ay) + t_coord'(w_frame[MAX_LEVELS].by);
    assign w_corr_x = w_sum_x + t_coord'({1'b0, w_sum_x[COORD_W-1]});
    assign w_corr_y = w_sum_y + t_coord'({1'b0, w_sum_y[COORD_W-1]});
    assign w_sum_x_half = AXIS_W'(w_corr_x >>> 1);
    assign w_sum_y_half = AXIS_W'(w_corr_y >>> 1);

    assign w_done = w_token[MAX_LEVELS];
    assign w_push = (w_accept && w_reject) || w_done;

    always_comb begin
        w_push_res = '0;
        if (w_done) begin
            w_push_res.x     = w_frame[MAX_LEVELS].x + t_coord'(w_sum_x_half);
            w_push_res.y     = w_frame[MAX_LEVELS].y + t_coord'(w_sum_y_half);
            w_push_res.valid = 1'b1;
            w_push_res.last  = r_finished;
        end
    end

    // Two-entry output buffer
    assign w_take = r_out_valid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_push) begin
            if (!r_out_valid || w_take) begin
                r_out       <= w_push_res;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= w_push_res;
                r_skid_valid <= 1'b1;
            end
        end else if (w_take) begin
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign s_axis_tready = i_rst_n && !r_busy && !r_skid_valid;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out.y, r_out.x};
    assign m_axis_tuser  = r_out.valid;
    assign m_axis_tlast  = r_out.last;

    // Checks
`include "hilbert_curve_point_generator_assert.svh"

    `HCPG_ASSERT_NOW(a_skid_behind_out, r_skid_valid, r_out_valid,
        "second buffer entry filled while first is empty")
    `HCPG_ASSERT_NOW(a_one_token, 1'b1, $onehot0(w_token) && (r_busy || (w_token == '0)),
        "cell row holds a stray or duplicate word")
    `HCPG_ASSERT_NEXT(a_restart_launch, w_accept && w_restart,
        r_launch && (r_point_index == '0), "restart did not launch the first vertex")
    `HCPG_ASSERT_NEXT(a_finished_held, r_busy, $stable(r_finished),
        "finished flag changed while a vertex is in flight")

endmodule

@@ tb/tb_hilbert_curve_point_generator.sv @@
// Self-checking testbench for hilbert_curve_point_generator: streams restart and
// next-point requests, predicts each curve vertex and checks the result stream.
// Depends on hcpg_pkg, hcpg_cell, the RTL top level and its assertion header.
module tb_hilbert_curve_point_generator
    import hcpg_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_LVL     = 16;
    localparam int DRAIN_CYC   = MAX_LVL + 4;   // one vertex pass plus margin
    localparam int LIMIT_CYC   = 400000;
    localparam int N_PHASES    = 15;
    localparam int PHASE_ITEMS = 72;
    localparam int HOLD_CYC    = 500;
    localparam int MAX_REPORTS = 10;

    localparam logic [CFG_A_W-1:0] CFG_UNUSED = 3'd7;
    localparam logic REQ_NEXT    = 1'b0;
    localparam logic REQ_RESTART = 1'b1;

    // idling per phase: none, sender, receiver, both
    localparam int SEND_IDLE [4] = '{0, 75, 0, 16};
    localparam int RECV_STALL[4] = '{0, 0, 75, 16};

    typedef enum logic {ROW_REQ, ROW_CFG} t_row_kind;

    // one result word as the predictor sees it
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               valid;
        logic               last;
    } t_point;

    // one request, optionally with a hand-written expected word
    typedef struct packed {
        logic   restart;
        logic   has_lit;
        t_point lit;
    } t_req;

    typedef struct packed {
        t_row_kind          kind;
        logic [CFG_A_W-1:0] idx;
        logic [CFG_W-1:0]   data;
        t_req               req;
    } t_row;

    // DUT ports
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [CFG_A_W-1:0] i_cfg_addr = '0;
    logic [CFG_W-1:0]   i_cfg_data = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata = '0;     // [0] restart, [7:1] zero
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [39:0]        m_axis_tdata;          // [17:0] point_x, [35:18] point_y
    logic               m_axis_tuser;          // [0] valid_res
    logic               m_axis_tlast;          // is_last

    // predictor state, starts at the reset values
    logic [ORG_W-1:0] org_x = '0;
    logic [ORG_W-1:0] org_y = '0;
    t_axis            a_x = 17'sd256;
    t_axis            a_y = '0;
    t_axis            b_x = '0;
    t_axis            b_y = 17'sd256;
    logic [LVL_W-1:0] lvl_reg = 5'd4;
    logic [31:0]      pt_idx = '0;
    logic             curve_done = 1'b1;

    // stimulus bookkeeping
    t_req   req_q[$];
    t_req   cur_req;
    t_point pending_pts[$];
    t_row   dir_rows[$];
    int     n_pushed = 0;
    int     n_taken = 0;
    int     mismatch = 0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    int     hold_left = 0;

    hilbert_curve_point_generator #(
        .MAX_LEVELS(MAX_LVL)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Vertex of point idx on a curve of lv levels; halving truncates toward zero
    function automatic t_point curve_vertex(input logic [31:0] idx, input int lv);
        longint x, y, ax, ay, bx, by, hax, hay, hbx, hby;
        logic [1:0] d;
        int k;
        t_point p;
        x  = org_x;
        y  = org_y;
        ax = a_x;
        ay = a_y;
        bx = b_x;
        by = b_y;
        for (k = 0; k < lv; k++) begin
            d   = 2'(idx >> (2 * (lv - 1 - k)));
            hax = ax / 2;
            hay = ay / 2;
            hbx = bx / 2;
            hby = by / 2;
            case (d)
                QUAD_SWAP: begin
                    ax = hbx; ay = hby; bx = hax; by = hay;
                end
                QUAD_FIRST: begin
                    x  = x + hax;
                    y  = y + hay;
                    ax = hax; ay = hay; bx = hbx; by = hby;
                end
                QUAD_BOTH: begin
                    x  = x + hax + hbx;
                    y  = y + hay + hby;
                    ax = hax; ay = hay; bx = hbx; by = hby;
                end
                QUAD_FLIP: begin
                    x  = x + hax + bx;
                    y  = y + hay + by;
                    ax = -hbx; ay = -hby; bx = -hax; by = -hay;
                end
                default: ;
            endcase
        end
        x = x + (ax + bx) / 2;
        y = y + (ay + by) / 2;
        p       = '0;
        p.x     = x[COORD_W-1:0];
        p.y     = y[COORD_W-1:0];
        p.valid = 1'b1;
        return p;
    endfunction

    // Advance the traversal by one request and return the word it produces
    function automatic t_point advance_curve(input logic restart);
        int lv;
        logic [63:0] last_idx, nxt;
        t_point p;
        lv       = (lvl_reg > MAX_LVL) ? MAX_LVL : int'(lvl_reg);
        last_idx = (64'd1 << (2 * lv)) - 64'd1;
        p        = '0;
        if (restart) begin
            nxt = '0;
        end else begin
            if (curve_done)
                return p;
            nxt = {32'd0, pt_idx} + 64'd1;
            if (nxt > last_idx) begin
                curve_done = 1'b1;
                return p;
            end
        end
        pt_idx     = nxt[31:0];
        curve_done = (nxt == last_idx);
        p          = curve_vertex(pt_idx, lv);
        p.last     = curve_done;
        return p;
    endfunction

    function automatic void add_req(input logic restart, input logic has_lit = 1'b0,
                                    input int x = 0, input int y = 0,
                                    input logic v = 1'b0, input logic l = 1'b0);
        t_row r;
        r                   = '0;
        r.kind              = ROW_REQ;
        r.req.restart       = restart;
        r.req.has_lit       = has_lit;
        r.req.lit.x         = x[COORD_W-1:0];
        r.req.lit.y         = y[COORD_W-1:0];
        r.req.lit.valid     = v;
        r.req.lit.last      = l;
        dir_rows.insert(dir_rows.size(), r);
    endfunction

    function automatic void add_cfg(input logic [CFG_A_W-1:0] idx, input int data);
        t_row r;
        r      = '0;
        r.kind = ROW_CFG;
        r.idx  = idx;
        r.data = data[CFG_W-1:0];
        dir_rows.insert(dir_rows.size(), r);
    endfunction

    function automatic logic [CFG_W-1:0] pick_origin();
        case ($urandom_range(3))
            0:       return '0;
            1:       return CFG_W'(65535);
            default: return CFG_W'($urandom_range(65535));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_axis();
        int v;
        v = int'($urandom_range(131070)) - 65535;
        case ($urandom_range(5))
            0:       return CFG_W'(-65535);
            1:       return CFG_W'(65535);
            2:       return '0;
            default: return v[CFG_W-1:0];
        endcase
    endfunction

    // mostly shallow curves so that whole traversals fit in a phase
    function automatic logic [CFG_W-1:0] pick_levels();
        case ($urandom_range(9))
            0, 1, 2, 3: return CFG_W'($urandom_range(2));
            4, 5:       return CFG_W'(3);
            6:          return CFG_W'(MAX_LVL);
            7, 8:       return CFG_W'($urandom_range(MAX_LVL, 4));
            default:    return CFG_W'($urandom_range(31, MAX_LVL + 1));
        endcase
    endfunction

    task automatic push_req(input t_req r);
        req_q.insert(req_q.size(), r);
        n_pushed++;
    endtask

    task automatic push_plain(input logic restart);
        t_req r;
        r         = '0;
        r.restart = restart;
        push_req(r);
    endtask

    // Register write; the block is idle whenever this is called
    task automatic cfg_write(input logic [CFG_A_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_ORIGIN_X:      org_x = data[ORG_W-1:0];
            REG_ORIGIN_Y:      org_y = data[ORG_W-1:0];
            REG_FIRST_AXIS_X:  a_x = data[AXIS_W-1:0];
            REG_FIRST_AXIS_Y:  a_y = data[AXIS_W-1:0];
            REG_SECOND_AXIS_X: b_x = data[AXIS_W-1:0];
            REG_SECOND_AXIS_Y: b_y = data[AXIS_W-1:0];
            REG_LEVELS:        lvl_reg = data[LVL_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // All requests taken and answered, then let the pipeline settle
    task automatic wait_idle();
        while (n_taken != n_pushed || pending_pts.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    // Request side: predict on acceptance, then offer the next word
    initial begin : req_driver
        t_point got;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
                got = advance_curve(cur_req.restart);
                if (cur_req.has_lit)
                    pending_pts.insert(pending_pts.size(), cur_req.lit);
                else
                    pending_pts.insert(pending_pts.size(), got);
                n_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_req = req_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {7'd0, cur_req.restart};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result side: compare each word with the oldest prediction
    initial begin : result_monitor
        t_point exp_pt, got_pt;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                got_pt.x     = m_axis_tdata[COORD_W-1:0];
                got_pt.y     = m_axis_tdata[2*COORD_W-1:COORD_W];
                got_pt.valid = m_axis_tuser;
                got_pt.last  = m_axis_tlast;
                if (pending_pts.size() == 0) begin
                    mismatch++;
                    if (mismatch <= MAX_REPORTS)
                        $display("unexpected word: x %0d y %0d valid %0b last %0b",
                                 $signed(got_pt.x), $signed(got_pt.y),
                                 got_pt.valid, got_pt.last);
                end else begin
                    exp_pt = pending_pts.pop_front();
                    if (got_pt !== exp_pt || m_axis_tdata[39:2*COORD_W] !== '0) begin
                        mismatch++;
                        if (mismatch <= MAX_REPORTS)
                            $display("exp/got x %0d/%0d y %0d/%0d v %0b/%0b l %0b/%0b pad %h",
                                     $signed(exp_pt.x), $signed(got_pt.x),
                                     $signed(exp_pt.y), $signed(got_pt.y),
                                     exp_pt.valid, got_pt.valid,
                                     exp_pt.last, got_pt.last,
                                     m_axis_tdata[39:2*COORD_W]);
                    end
                end
            end
            // long hold-off first, otherwise random stalls
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin : watchdog
        int cyc;
        cyc = 0;
        while (cyc < LIMIT_CYC) begin
            @(posedge i_clk);
            cyc++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        int lv, n, seq_len, p;
        // not started yet, then the first vertex of the reset square
        add_req(REQ_NEXT, 1'b1, 0, 0, 1'b0, 1'b0);
        add_req(REQ_RESTART, 1'b1, 8, 8, 1'b1, 1'b0);
        add_req(REQ_NEXT);
        add_req(REQ_NEXT);
        // one level: full traversal, last flagged, then nothing
        add_cfg(REG_LEVELS, 1);
        add_req(REQ_RESTART);
        add_req(REQ_NEXT);
        add_req(REQ_NEXT);
        add_req(REQ_NEXT);
        add_req(REQ_NEXT, 1'b1, 0, 0, 1'b0, 1'b0);
        // zero levels: single centre vertex
        add_cfg(REG_LEVELS, 0);
        add_cfg(REG_ORIGIN_X, 100);
        add_cfg(REG_ORIGIN_Y, 200);
        add_req(REQ_RESTART, 1'b1, 228, 328, 1'b1, 1'b1);
        add_req(REQ_NEXT, 1'b1, 0, 0, 1'b0, 1'b0);
        // largest corner and axes
        add_cfg(REG_ORIGIN_X, 65535);
        add_cfg(REG_ORIGIN_Y, 65535);
        add_cfg(REG_FIRST_AXIS_X, 65535);
        add_cfg(REG_SECOND_AXIS_Y, 65535);
        add_req(REQ_RESTART, 1'b1, 98302, 98302, 1'b1, 1'b1);
        // most negative axes: halving rounds toward zero
        add_cfg(REG_ORIGIN_X, 0);
        add_cfg(REG_ORIGIN_Y, 0);
        add_cfg(REG_FIRST_AXIS_X, -65535);
        add_cfg(REG_SECOND_AXIS_Y, -65535);
        add_req(REQ_RESTART, 1'b1, -32767, -32767, 1'b1, 1'b1);
        // depth lowered mid-traversal ends the curve
        add_cfg(REG_FIRST_AXIS_Y, 300);
        add_cfg(REG_SECOND_AXIS_X, -700);
        add_cfg(REG_LEVELS, 2);
        add_req(REQ_RESTART);
        add_req(REQ_NEXT);
        add_req(REQ_NEXT);
        add_req(REQ_NEXT);
        add_cfg(REG_LEVELS, 1);
        add_req(REQ_NEXT, 1'b1, 0, 0, 1'b0, 1'b0);
        add_req(REQ_NEXT, 1'b1, 0, 0, 1'b0, 1'b0);
        // unused index ignored; depth above the maximum is clamped
        add_cfg(CFG_UNUSED, 'h1FFFF);
        add_cfg(REG_LEVELS, 31);
        add_req(REQ_RESTART);
        add_req(REQ_NEXT);
        add_req(REQ_NEXT);
        add_cfg(REG_LEVELS, MAX_LVL + 1);
        add_req(REQ_NEXT);
        add_req(REQ_RESTART);
        add_req(REQ_RESTART);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                wait_idle();
                cfg_write(dir_rows[i].idx, dir_rows[i].data);
            end else begin
                push_req(dir_rows[i].req);
            end
        end

        // random phases: new square and depth, then restart-led runs
        for (p = 0; p < N_PHASES; p++) begin
            wait_idle();
            send_idle_pct  = SEND_IDLE[p % 4];
            recv_stall_pct = RECV_STALL[p % 4];
            cfg_write(REG_ORIGIN_X, pick_origin());
            cfg_write(REG_ORIGIN_Y, pick_origin());
            cfg_write(REG_FIRST_AXIS_X, pick_axis());
            cfg_write(REG_FIRST_AXIS_Y, pick_axis());
            cfg_write(REG_SECOND_AXIS_X, pick_axis());
            cfg_write(REG_SECOND_AXIS_Y, pick_axis());
            cfg_write(REG_LEVELS, pick_levels());
            if ($urandom_range(3) == 0)
                cfg_write(CFG_UNUSED, CFG_W'($urandom));
            // receiver holds off so the output buffer fills and input stalls
            if (p == 1)
                hold_left = HOLD_CYC;
            lv = (lvl_reg > MAX_LVL) ? MAX_LVL : int'(lvl_reg);
            n  = 0;
            while (n < PHASE_ITEMS) begin
                if ($urandom_range(9) == 0) begin
                    push_plain(1'($urandom));
                    n++;
                end else begin
                    if (lv <= 3)
                        seq_len = (1 << (2 * lv)) - 1 + $urandom_range(2);
                    else
                        seq_len = $urandom_range(40, 1);
                    // a broken run: restarted early
                    if ($urandom_range(7) == 0)
                        seq_len = $urandom_range(seq_len);
                    push_plain(REQ_RESTART);
                    repeat (seq_len) push_plain(REQ_NEXT);
                    n += seq_len + 1;
                end
            end
        end

        wait_idle();
        if (mismatch == 0 && pending_pts.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
